@@ rtl/response_time_analysis_assert.svh @@
// assertion macros used by the rta_ctrl module
`ifndef RESPONSE_TIME_ANALYSIS_ASSERT_SVH
`define RESPONSE_TIME_ANALYSIS_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RTA_ASSERT_IMP(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("rta check failed");

// implication with the consequent checked in the cycle after the antecedent
`define RTA_ASSERT_NXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("rta check failed");

`endif

@@ rtl/rta_pkg.sv @@
// ----------------------------------------------------------------------------
// rta_pkg
// types and codes shared by the response time analysis block
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int ITER_WIDTH = 24;
    localparam int STATUS_WIDTH = 2;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_SCHED = 2'd1,
        ST_MISS  = 2'd2,
        ST_LIMIT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_ITER,
        S_RD,
        S_RDW,
        S_QDIV,
        S_DIVW,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_query;
        logic write_entry;
        logic form_base;
        logic start_iter;
        logic rd_entry;
        logic start_div;
        logic do_mul;
        logic do_acc;
        logic next_round;
        logic set_result;
        status_t result_status;
        logic [1:0] result_kind; // 0 zero, 1 base, 2 deadline plus one, 3 r
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic base_miss;
        logic entry_sel;
        logic last_entry;
        logic c_zero;
        logic t_zero;
        logic div_done;
        logic acc_over;
        logic fixed_point;
        logic iter_limit;
    } dp_stat_t;

    localparam logic [1:0] RK_ZERO = 2'd0;
    localparam logic [1:0] RK_BASE = 2'd1;
    localparam logic [1:0] RK_DLP1 = 2'd2;
    localparam logic [1:0] RK_R    = 2'd3;

endpackage

@@ rtl/rta_ram.sv @@
// ----------------------------------------------------------------------------
// rta_ram
// generic single port write, registered read memory
// ----------------------------------------------------------------------------
module rta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/rta_div.sv @@
// ----------------------------------------------------------------------------
// rta_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rta_div #(
    parameter int W = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/rta_datapath.sv @@
// ----------------------------------------------------------------------------
// rta_datapath
// entry table, divider, multiplier and accumulator of the recurrence
// ----------------------------------------------------------------------------
module rta_datapath #(
    parameter int NUM_MESSAGES = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rta_pkg::dp_cmd_t              cmd,
    output rta_pkg::dp_stat_t             stat,
    input  logic [3:0]                    msg_index,
    input  logic [TIME_WIDTH-1:0]         period,
    input  logic [TIME_WIDTH-1:0]         wcet,
    input  logic [TIME_WIDTH-1:0]         jitter,
    input  logic [TIME_WIDTH-1:0]         deadline,
    input  logic [TIME_WIDTH-1:0]         blocking,
    input  logic [15:0]                   higher_mask,
    input  logic [rta_pkg::ITER_WIDTH-1:0] max_iterations,
    output logic [1:0]                    res_status,
    output logic [TIME_WIDTH+1:0]         res_response
);
    import rta_pkg::*;

    localparam int AW = (NUM_MESSAGES > 1) ? $clog2(NUM_MESSAGES) : 1;
    localparam int RW = TIME_WIDTH + 2;
    localparam int PW = 2 * RW;

    logic [RW-1:0] base_reg, r_reg, acc_reg, dl_reg;
    logic [NUM_MESSAGES-1:0] mask_reg;
    logic [AW-1:0] h_reg;
    logic [ITER_WIDTH-1:0] it_reg;
    logic [TIME_WIDTH-1:0] t_rd, c_rd, j_rd;
    logic [RW-1:0] q_reg;
    logic [PW-1:0] prod_reg;
    logic [RW-1:0] quo;
    logic div_done;
    logic [1:0] rs_reg;
    logic [RW-1:0] rr_reg;
    logic we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] hcur;
    logic [AW-1:0] raddr;
    logic [RW-1:0] dividend;
    logic [RW:0] sum;

    assign we    = cmd.write_entry && (32'(msg_index) < NUM_MESSAGES);
    assign waddr = AW'(msg_index);

    // the pointer has moved on after a read; hold the entry in work on the outputs
    assign hcur  = h_reg - 1'b1;
    assign raddr = cmd.rd_entry ? h_reg : hcur;

    rta_ram #(.WIDTH(TIME_WIDTH), .DEPTH(NUM_MESSAGES)) u_per (
        .clk(clk), .we(we), .waddr(waddr), .wdata(period), .raddr(raddr), .rdata(t_rd));
    rta_ram #(.WIDTH(TIME_WIDTH), .DEPTH(NUM_MESSAGES)) u_wcet (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcet), .raddr(raddr), .rdata(c_rd));
    rta_ram #(.WIDTH(TIME_WIDTH), .DEPTH(NUM_MESSAGES)) u_jit (
        .clk(clk), .we(we), .waddr(waddr), .wdata(jitter), .raddr(raddr), .rdata(j_rd));

    // ceil((r + j) / t) = (r + j + t - 1) / t
    assign dividend = r_reg + RW'(j_rd) + RW'(t_rd) - RW'(1);

    rta_div #(.W(RW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.start_div), .dividend(dividend),
        .divisor(RW'(t_rd)), .done(div_done), .quotient(quo));

    assign sum = {1'b0, acc_reg} + (RW + 1)'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            base_reg <= RW'(jitter) + RW'(wcet) + RW'(blocking);
            dl_reg   <= RW'(deadline);
            for (int i = 0; i < NUM_MESSAGES; i++)
            begin
                mask_reg[i] <= (i < 16) ? higher_mask[i % 16] : 1'b0;
            end
        end
        if (cmd.start_iter)
        begin
            acc_reg <= base_reg;
            h_reg   <= '0;
        end
        if (cmd.form_base)
        begin
            r_reg <= base_reg;
        end
        if (cmd.rd_entry)
        begin
            h_reg <= h_reg + 1'b1;
        end
        if (div_done)
        begin
            q_reg <= quo;
        end
        if (cmd.do_mul)
        begin
            prod_reg <= PW'(q_reg) * PW'(c_rd);
        end
        if (cmd.do_acc)
        begin
            acc_reg <= sum[RW-1:0];
        end
        if (cmd.next_round)
        begin
            r_reg <= acc_reg;
        end
        if (cmd.set_result)
        begin
            rs_reg <= cmd.result_status;
            unique case (cmd.result_kind)
                RK_ZERO: rr_reg <= '0;
                RK_BASE: rr_reg <= base_reg;
                RK_DLP1: rr_reg <= dl_reg + RW'(1);
                RK_R:    rr_reg <= r_reg;
                default: rr_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= '0;
        end
        else if (cmd.form_base)
        begin
            it_reg <= '0;
        end
        else if (cmd.start_iter)
        begin
            it_reg <= it_reg + 1'b1;
        end
    end

    assign stat.base_miss   = base_reg > dl_reg;
    assign stat.entry_sel   = mask_reg[h_reg];
    assign stat.last_entry  = (32'(h_reg) == NUM_MESSAGES - 1);
    assign stat.c_zero      = (c_rd == '0);
    assign stat.t_zero      = (t_rd == '0);
    assign stat.div_done    = div_done;
    assign stat.acc_over    = (prod_reg[PW-1:RW] != '0) || sum[RW] || (sum[RW-1:0] > dl_reg);
    assign stat.fixed_point = (acc_reg == r_reg);
    assign stat.iter_limit  = (it_reg >= max_iterations);

    assign res_status   = rs_reg;
    assign res_response = rr_reg;

endmodule

@@ rtl/rta_ctrl.sv @@
// ----------------------------------------------------------------------------
// rta_ctrl
// sequencer of load and query items
// ----------------------------------------------------------------------------
module rta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              req_type,
    input  logic              out_free,
    input  logic              last_done,
    output logic              idle,
    output logic              out_load,
    output rta_pkg::dp_cmd_t  cmd,
    input  rta_pkg::dp_stat_t stat
);
    import rta_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = req_type ? S_BASE : S_OUT;
                end
            end
            S_BASE:  state_next = stat.base_miss ? S_OUT : S_ITER;
            S_ITER:  state_next = stat.iter_limit ? S_OUT : S_RD;
            S_RD:
            begin
                last_next  = stat.last_entry;
                state_next = stat.entry_sel ? S_RDW : (stat.last_entry ? S_CHECK : S_RD);
            end
            S_RDW:
            begin
                if (stat.c_zero)
                begin
                    state_next = last_reg ? S_CHECK : S_RD;
                end
                else if (stat.t_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV:  state_next = S_DIVW;
            S_DIVW:  state_next = stat.div_done ? S_MUL : S_DIVW;
            S_MUL:   state_next = S_ACC;
            S_ACC:
            begin
                if (stat.acc_over)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = last_reg ? S_CHECK : S_RD;
                end
            end
            S_CHECK: state_next = stat.fixed_point ? S_OUT : S_ITER;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OUT && !out_free)
        begin
            state_next = S_OUT;
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.result_status = ST_LOAD;
        cmd.result_kind   = RK_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_query  = in_fire;
                cmd.write_entry = in_fire && !req_type;
                cmd.set_result  = in_fire && !req_type;
            end
            S_BASE:
            begin
                cmd.form_base     = 1'b1;
                cmd.set_result    = stat.base_miss;
                cmd.result_status = ST_MISS;
                cmd.result_kind   = RK_BASE;
            end
            S_ITER:
            begin
                cmd.start_iter    = !stat.iter_limit;
                cmd.set_result    = stat.iter_limit;
                cmd.result_status = ST_LIMIT;
            end
            S_RD:    cmd.rd_entry = 1'b1;
            S_RDW:
            begin
                cmd.set_result    = !stat.c_zero && stat.t_zero;
                cmd.result_status = ST_MISS;
                cmd.result_kind   = RK_DLP1;
            end
            S_QDIV:  cmd.start_div = 1'b1;
            S_MUL:   cmd.do_mul = 1'b1;
            S_ACC:
            begin
                cmd.do_acc        = !stat.acc_over;
                cmd.set_result    = stat.acc_over;
                cmd.result_status = ST_MISS;
                cmd.result_kind   = RK_DLP1;
            end
            S_CHECK:
            begin
                cmd.next_round    = 1'b1;
                cmd.set_result    = stat.fixed_point;
                cmd.result_status = ST_SCHED;
                cmd.result_kind   = RK_R;
            end
            default: ;
        endcase
    end

    assign idle     = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    `include "response_time_analysis_assert.svh"
    `RTA_ASSERT_IMP(a_load_idle, in_fire, state_reg == S_IDLE)
    `RTA_ASSERT_NXT(a_out_leave, out_load, state_reg == S_IDLE)
    `RTA_ASSERT_IMP(a_div_state, cmd.start_div, state_reg == S_QDIV)
    `RTA_ASSERT_IMP(a_done_frees, last_done && state_reg == S_OUT, out_load)
    `RTA_ASSERT_NXT(a_result_out, cmd.set_result, state_reg == S_OUT)

endmodule

@@ rtl/response_time_analysis.sv @@
// ----------------------------------------------------------------------------
// response_time_analysis
// fixed priority response time analysis with release jitter
// ----------------------------------------------------------------------------
// channel   dir  handshake                          payload
// s_axis    in   s_axis_tvalid / s_axis_tready      tdata, tuser = req_type
// m_axis    out  m_axis_tvalid / m_axis_tready      tdata = status, response
// cfg       in   cfg_valid / cfg_ready              cfg_data = max_iterations
//
// a load goes from idle straight to the output state; a query forms the base,
// then each iteration reads every entry and, for each masked entry with nonzero
// wcet, runs the serial divider, the multiply and the accumulate before the
// fixed point check. one item is in work at a time; a finished word sits in the
// output register while the next item is taken.
// reset is asynchronous, active low; the entry table is not cleared.
module response_time_analysis #(
    parameter int NUM_MESSAGES = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // msg_index, period, wcet, jitter, deadline, blocking, higher_mask
    input  logic [((4 + 5 * TIME_WIDTH + 16 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, response
    output logic [((TIME_WIDTH + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [rta_pkg::ITER_WIDTH-1:0] cfg_data
);
    import rta_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int OW = ((TW + 4 + 7) / 8) * 8;

    logic in_fire, idle, out_load, out_free;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [ITER_WIDTH-1:0] max_it_reg;
    logic ov_reg;
    logic [1:0] rs;
    logic [TW+1:0] rr;
    logic [1:0] st_reg;
    logic [TW+1:0] rp_reg;

    assign s_axis_tready = idle;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_it_reg <= '1;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_it_reg <= cfg_data;
            end
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            st_reg <= rs;
            rp_reg <= rr;
        end
    end

    rta_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .req_type(s_axis_tuser),
        .out_free(out_free), .last_done(ov_reg && m_axis_tready), .idle(idle),
        .out_load(out_load), .cmd(cmd), .stat(stat));

    rta_datapath #(.NUM_MESSAGES(NUM_MESSAGES), .TIME_WIDTH(TW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .msg_index(s_axis_tdata[3:0]),
        .period(s_axis_tdata[4 +: TW]),
        .wcet(s_axis_tdata[4 + TW +: TW]),
        .jitter(s_axis_tdata[4 + 2 * TW +: TW]),
        .deadline(s_axis_tdata[4 + 3 * TW +: TW]),
        .blocking(s_axis_tdata[4 + 4 * TW +: TW]),
        .higher_mask(s_axis_tdata[4 + 5 * TW +: 16]),
        .max_iterations(max_it_reg),
        .res_status(rs), .res_response(rr));

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = OW'({rp_reg, st_reg});

endmodule

@@ tb/tb_response_time_analysis.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_response_time_analysis
// self-checking bench for the response time analysis block
// ----------------------------------------------------------------------------
// loads the message table, then sends a table of directed queries and a long
// run of random loads and queries under several idling mixes and iteration
// limits. each returned word is checked, in order, against a stored answer or a
// local model of the recurrence.
module tb_response_time_analysis;

    import rta_pkg::*;

    localparam int NUM_MSG     = 16;
    localparam int TW          = 32;
    localparam int RESP_W      = TW + 2;
    localparam int IN_W        = ((4 + 5 * TW + 16 + 7) / 8) * 8;
    localparam int OUT_W       = ((TW + 4 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 200000;
    localparam int COST_BUDGET = 20000;
    localparam int SCREEN_ROUNDS = 200;
    localparam logic [ITER_WIDTH-1:0] ITER_MAX = '1;

    typedef struct {
        logic            req;
        logic [3:0]      idx;
        logic [TW-1:0]   period;
        logic [TW-1:0]   wcet;
        logic [TW-1:0]   jitter;
        logic [TW-1:0]   deadline;
        logic [TW-1:0]   blocking;
        logic [15:0]     mask;
    } rta_item_t;

    typedef struct {
        status_t           st;
        logic [RESP_W-1:0] resp;
    } rta_answer_t;

    typedef struct {
        bit                    cfg_en;
        logic [ITER_WIDTH-1:0] cfg_val;
        rta_item_t             item;
        bit                    fixed;
        rta_answer_t           answer;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;   // msg_index, period, wcet, jitter, deadline, blocking, mask
    logic s_axis_tuser;              // req_type
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;  // status, response
    logic cfg_valid;
    logic cfg_ready;
    logic [ITER_WIDTH-1:0] cfg_data;

    // local copy of the block state
    logic [TW-1:0]         tab_period [NUM_MSG];
    logic [TW-1:0]         tab_wcet   [NUM_MSG];
    logic [TW-1:0]         tab_jitter [NUM_MSG];
    logic [ITER_WIDTH-1:0] iter_limit;

    rta_answer_t pending_answers [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 1'b0;

    always #5 clk = ~clk;

    response_time_analysis #(
        .NUM_MESSAGES (NUM_MSG),
        .TIME_WIDTH   (TW)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // one pass of the recurrence loop per round, bounded by lim
    function automatic void analyse(input rta_item_t it, input logic [ITER_WIDTH-1:0] lim,
                                    output rta_answer_t ans, output int unsigned rounds);
        logic [63:0] base;
        logic [63:0] dl;
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] q;
        logic [63:0] room;
        logic [63:0] t;
        logic [63:0] c;
        bit          over;
        base = 64'(it.jitter) + 64'(it.wcet) + 64'(it.blocking);
        dl = 64'(it.deadline);
        rounds = 0;
        if (base > dl)
        begin
            ans.st = ST_MISS;
            ans.resp = RESP_W'(base);
            return;
        end
        r = base;
        while (1)
        begin
            if (rounds >= lim)
            begin
                ans.st = ST_LIMIT;
                ans.resp = '0;
                break;
            end
            rounds++;
            acc = base;
            over = 1'b0;
            for (int h = 0; h < NUM_MSG; h++)
            begin
                c = 64'(tab_wcet[h]);
                t = 64'(tab_period[h]);
                if (!it.mask[h] || c == 0)
                    continue;
                if (t == 0)
                begin
                    over = 1'b1;
                    break;
                end
                q = (r + 64'(tab_jitter[h]) + t - 1) / t;
                room = dl - acc;
                if (q > room / c)
                begin
                    over = 1'b1;
                    break;
                end
                acc += q * c;
            end
            if (over)
            begin
                ans.st = ST_MISS;
                ans.resp = RESP_W'(dl + 1);
                break;
            end
            if (acc == r)
            begin
                ans.st = ST_SCHED;
                ans.resp = RESP_W'(r);
                break;
            end
            r = acc;
        end
    endfunction

    // applies an accepted word to the local state and gives its answer
    function automatic rta_answer_t accept_item(input rta_item_t it);
        rta_answer_t ans;
        int unsigned rounds;
        if (!it.req)
        begin
            tab_period[it.idx] = it.period;
            tab_wcet[it.idx] = it.wcet;
            tab_jitter[it.idx] = it.jitter;
            ans.st = ST_LOAD;
            ans.resp = '0;
        end
        else
            analyse(it, iter_limit, ans, rounds);
        return ans;
    endfunction

    // random time value with a random number of significant bits
    function automatic logic [TW-1:0] rnd_time();
        int unsigned width;
        logic [TW-1:0] v;
        width = $urandom_range(0, TW);
        v = $urandom;
        if (width < TW)
            v &= TW'((64'd1 << width) - 1);
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ERROR %s", $realtime, what);
    endtask

    task automatic send_item(input rta_item_t it, input bit fixed, input rta_answer_t answer);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.req;
        s_axis_tdata <= {4'b0, it.mask, it.blocking, it.deadline, it.jitter, it.wcet,
                         it.period, it.idx};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        if (fixed)
        begin
            void'(accept_item(it));
            pending_answers.push_back(answer);
        end
        else
            pending_answers.push_back(accept_item(it));
    endtask

    task automatic write_iter_limit(input logic [ITER_WIDTH-1:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (50) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        iter_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random item whose query stays within the cycle budget
    task automatic random_item(output rta_item_t it);
        rta_answer_t ans;
        int unsigned rounds;
        int unsigned cost;
        logic [ITER_WIDTH-1:0] lim;
        while (1)
        begin
            it.req = ($urandom_range(0, 99) >= 30);
            it.idx = 4'($urandom);
            it.period = rnd_time();
            if (it.period == 0)
                it.period = 1;
            it.wcet = rnd_time();
            it.jitter = rnd_time();
            it.deadline = rnd_time();
            it.blocking = rnd_time();
            it.mask = 16'($urandom);
            if ($urandom_range(0, 1))
                it.mask &= 16'($urandom);
            if (!it.req)
                break;
            lim = (iter_limit > SCREEN_ROUNDS) ? ITER_WIDTH'(SCREEN_ROUNDS) : iter_limit;
            analyse(it, lim, ans, rounds);
            if (ans.st == ST_LIMIT && iter_limit > SCREEN_ROUNDS)
                continue;
            cost = rounds * (NUM_MSG + 8 + $countones(it.mask) * (TW + 8));
            if (cost <= COST_BUDGET)
                break;
        end
    endtask

    // receiver side
    always @(negedge clk)
        m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        rta_answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[1:0] !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[1:0], want.st));
                if (m_axis_tdata[RESP_W+1:2] !== want.resp)
                    report_mismatch($sformatf("response %h, expected %h",
                                              m_axis_tdata[RESP_W+1:2], want.resp));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        directed_row_t rows [$];
        directed_row_t row;
        rta_item_t it;
        rta_answer_t none;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        iter_limit = ITER_MAX;
        none.st = ST_LOAD;
        none.resp = '0;
        for (int h = 0; h < NUM_MSG; h++)
        begin
            tab_period[h] = '0;
            tab_wcet[h] = '0;
            tab_jitter[h] = '0;
        end

        // table loads: every entry written before any query reads it
        for (int h = 0; h < NUM_MSG; h++)
        begin
            row = '{cfg_en: 0, cfg_val: '0, item: '{default: '0}, fixed: 1, answer: none};
            row.item.idx = 4'(h);
            row.item.period = 32'd10 * (h + 1);
            row.item.wcet = h + 2;
            row.item.jitter = h;
            if (h == 14)
            begin
                row.item.period = 32'd1;
                row.item.wcet = '0;
            end
            if (h == 15)
            begin
                row.item.period = '1;
                row.item.wcet = '1;
                row.item.jitter = '1;
                row.item.mask = '1;
                row.item.deadline = '1;
                row.item.blocking = '1;
            end
            rows.push_back(row);
        end
        // base above the deadline
        row = '{cfg_en: 0, cfg_val: '0, item: '{default: '0}, fixed: 1, answer: none};
        row.item.req = 1'b1;
        row.item.wcet = '1;
        row.item.jitter = '1;
        row.item.blocking = '1;
        row.item.deadline = '1;
        row.answer = '{ST_MISS, 34'h2FFFFFFFD};
        rows.push_back(row);
        // all zero, no interference
        row = '{cfg_en: 0, cfg_val: '0, item: '{default: '0}, fixed: 1, answer: '{ST_SCHED, '0}};
        row.item.req = 1'b1;
        rows.push_back(row);
        // base exactly at the deadline
        row.item.jitter = 1;
        row.item.wcet = 2;
        row.item.blocking = 3;
        row.item.deadline = 6;
        row.answer = '{ST_SCHED, 34'd6};
        rows.push_back(row);
        // huge interferer overruns the largest deadline
        row = '{cfg_en: 0, cfg_val: '0, item: '{default: '0}, fixed: 1, answer: none};
        row.item.req = 1'b1;
        row.item.wcet = 1;
        row.item.deadline = '1;
        row.item.mask = 16'h8000;
        row.answer = '{ST_MISS, 34'h100000000};
        rows.push_back(row);
        // zero execution time entry and two real interferers
        row = '{cfg_en: 0, cfg_val: '0, item: '{default: '0}, fixed: 0, answer: none};
        row.item.req = 1'b1;
        row.item.wcet = 1;
        row.item.deadline = 1000;
        row.item.mask = 16'h4003;
        rows.push_back(row);
        // single iteration allowed: limit reached
        row.cfg_en = 1;
        row.cfg_val = ITER_WIDTH'(1);
        row.fixed = 1;
        row.answer = '{ST_LIMIT, '0};
        rows.push_back(row);
        row.cfg_en = 1;
        row.cfg_val = ITER_MAX;
        row.fixed = 0;
        row.item.mask = 16'h3FFF;
        row.item.deadline = 32'd100000;
        rows.push_back(row);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].cfg_en)
                write_iter_limit(rows[i].cfg_val);
            send_item(rows[i].item, rows[i].fixed, rows[i].answer);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_iter_limit(ITER_MAX);
                1: write_iter_limit(ITER_WIDTH'(1));
                2: write_iter_limit(ITER_WIDTH'($urandom_range(2, 40)));
                default: write_iter_limit(ITER_MAX);
            endcase
            idle_pct = (phase == 1) ? 51 : (phase == 3) ? 17 : 0;
            stall_pct = (phase == 2) ? 51 : (phase == 3) ? 17 : 0;
            if (phase == 0)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            repeat (225)
            begin
                random_item(it);
                send_item(it, 1'b0, none);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rta_pkg.sv
rtl/rta_ram.sv
rtl/rta_div.sv
rtl/rta_datapath.sv
rtl/rta_ctrl.sv
rtl/response_time_analysis.sv
tb/tb_response_time_analysis.sv
